// ----- rtl/core/tqt_pkg.sv -----
// tqt_pkg: shared types, constants and arithmetic helpers for the torus quad tessellator.
// No dependencies.
`default_nettype none
package tqt_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int FRAC_BITS    = 12;
    localparam int CNT_W        = 11;
    localparam int IDX_W        = 10;
    localparam int PH_W         = 32;
    localparam int DIV_STEPS    = CNT_W + PH_W;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_X0    = 652032874;
    localparam int LAST_CORNER  = 5;

    localparam logic [5:0] PICK_U = 6'b010110;
    localparam logic [5:0] PICK_V = 6'b110100;

    typedef enum logic [1:0] {
        REG_RING_RADIUS   = 2'd0,
        REG_TUBE_RADIUS   = 2'd1,
        REG_RING_SEGMENTS = 2'd2,
        REG_TUBE_SEGMENTS = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOAD,
        S_ROT
    } t_trig_state;

    typedef struct packed {
        logic [IDX_W-1:0] ring_index;
        logic [IDX_W-1:0] tube_index;
        logic             bad;
    } t_item;

    typedef struct packed {
        logic signed [15:0] cu0;
        logic signed [15:0] su0;
        logic signed [15:0] cu1;
        logic signed [15:0] su1;
        logic signed [15:0] cv0;
        logic signed [15:0] sv0;
        logic signed [15:0] cv1;
        logic signed [15:0] sv1;
        logic               bad;
    } t_trig;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } t_cs;

    function automatic logic [CNT_W-1:0] f_eff(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] e;
        if (n < CNT_W'(3)) begin
            e = CNT_W'(3);
        end else if (n > CNT_W'(MAX_SEGMENTS)) begin
            e = CNT_W'(MAX_SEGMENTS);
        end else begin
            e = n;
        end
        return e;
    endfunction

    function automatic logic signed [32:0] f_atan(input logic [3:0] k);
        logic signed [32:0] a;
        case (k)
            4'd0:    a = 33'sd536870912;
            4'd1:    a = 33'sd316933406;
            4'd2:    a = 33'sd167458907;
            4'd3:    a = 33'sd85004756;
            4'd4:    a = 33'sd42667331;
            4'd5:    a = 33'sd21354465;
            4'd6:    a = 33'sd10679838;
            4'd7:    a = 33'sd5340245;
            4'd8:    a = 33'sd2670163;
            4'd9:    a = 33'sd1335087;
            4'd10:   a = 33'sd667544;
            4'd11:   a = 33'sd333772;
            4'd12:   a = 33'sd166886;
            4'd13:   a = 33'sd83443;
            4'd14:   a = 33'sd41722;
            default: a = 33'sd20861;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] f_cordic_out(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [15:0] o;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            o = 16'sd16384;
        end else if (t < -34'sd16384) begin
            o = -16'sd16384;
        end else begin
            o = t[15:0];
        end
        return o;
    endfunction

    function automatic t_cs f_quad(input logic [1:0] q, input logic signed [15:0] x,
                                   input logic signed [15:0] y);
        t_cs r;
        case (q)
            2'd0:    begin r.c = x;  r.s = y;  end
            2'd1:    begin r.c = -y; r.s = x;  end
            2'd2:    begin r.c = -x; r.s = -y; end
            default: begin r.c = y;  r.s = -x; end
        endcase
        return r;
    endfunction

    function automatic logic signed [39:0] f_rnd14(input logic signed [39:0] v);
        return (v + 40'sd8192) >>> 14;
    endfunction

    function automatic logic signed [18:0] f_sat_pos(input logic signed [39:0] v);
        logic signed [18:0] o;
        if (v > 40'sd262143) begin
            o = 19'sd262143;
        end else if (v < -40'sd262144) begin
            o = -19'sd262144;
        end else begin
            o = v[18:0];
        end
        return o;
    endfunction

    function automatic logic signed [15:0] f_sat_q14(input logic signed [39:0] v);
        logic signed [15:0] o;
        if (v > 40'sd16384) begin
            o = 16'sd16384;
        end else if (v < -40'sd16384) begin
            o = -16'sd16384;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/torus_quad_tessellator.sv -----
// torus_quad_tessellator: top level; configuration registers, front queue, angle unit, emitter.
// Depends on tqt_pkg, tqt_front, tqt_trig, tqt_emit.
//
//   channel  signals                             direction
//   in       i_valid / o_stall, ring/tube index  into block
//   out      o_valid / i_stall, corner payload   out of block
//   cfg      i_cfg_we, i_cfg_index, i_cfg_data   into block, write only
//
// A quad passes 43 bit-serial phase division steps, a load state, 16 CORDIC rotations and a
// handoff in the angle unit; its six corners leave one a cycle unless the output stalls, while
// the next quad can enter the angle unit. Corners pass stage A, then the output register.
// Synchronous active-low reset empties the queue and pipeline and restores register defaults.
// An output stall freezes the emitter pipeline; the queue keeps accepting until full.
`default_nettype none
module torus_quad_tessellator
    import tqt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [IDX_W-1:0]    i_ring_index,
    input  wire logic [IDX_W-1:0]    i_tube_index,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [2:0]               o_corner,
    output logic signed [18:0]       o_pos_x,
    output logic signed [18:0]       o_pos_y,
    output logic signed [18:0]       o_pos_z,
    output logic signed [15:0]       o_norm_x,
    output logic signed [15:0]       o_norm_y,
    output logic signed [15:0]       o_norm_z,
    output logic                     o_last_corner,
    output logic                     o_bad_index,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    logic [15:0]      r_ring_radius, r_tube_radius;
    logic [CNT_W-1:0] r_ring_segments, r_tube_segments;
    logic             item_valid, pop, trig_valid, take;
    t_item            item;
    t_trig            trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_radius   <= 16'd4096;
            r_tube_radius   <= 16'd1024;
            r_ring_segments <= CNT_W'(32);
            r_tube_segments <= CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_RING_RADIUS:   r_ring_radius   <= i_cfg_data;
                REG_TUBE_RADIUS:   r_tube_radius   <= i_cfg_data;
                REG_RING_SEGMENTS: r_ring_segments <= i_cfg_data[CNT_W-1:0];
                REG_TUBE_SEGMENTS: r_tube_segments <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    tqt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_ring_index    (i_ring_index),
        .i_tube_index    (i_tube_index),
        .i_ring_segments (r_ring_segments),
        .i_tube_segments (r_tube_segments),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_pop           (pop)
    );

    tqt_trig u_trig (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_pop           (pop),
        .i_ring_segments (r_ring_segments),
        .i_tube_segments (r_tube_segments),
        .o_valid         (trig_valid),
        .o_trig          (trig),
        .i_take          (take)
    );

    tqt_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_trig_valid  (trig_valid),
        .i_trig        (trig),
        .o_take        (take),
        .i_ring_radius (r_ring_radius),
        .i_tube_radius (r_tube_radius),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_corner      (o_corner),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_norm_x      (o_norm_x),
        .o_norm_y      (o_norm_y),
        .o_norm_z      (o_norm_z),
        .o_last_corner (o_last_corner),
        .o_bad_index   (o_bad_index)
    );

endmodule
`default_nettype wire

// ----- rtl/core/tqt_front.sv -----
// tqt_front: input side; flags out-of-range indexes and queues items in a two-entry FIFO.
// Depends on tqt_pkg.
`default_nettype none
module tqt_front
    import tqt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [IDX_W-1:0]    i_ring_index,
    input  wire logic [IDX_W-1:0]    i_tube_index,
    input  wire logic [CNT_W-1:0]    i_ring_segments,
    input  wire logic [CNT_W-1:0]    i_tube_segments,
    output logic                     o_item_valid,
    output t_item                    o_item,
    input  wire logic                i_pop
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_item      item;

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        item.ring_index = i_ring_index;
        item.tube_index = i_tube_index;
        item.bad = ({1'b0, i_ring_index} >= f_eff(i_ring_segments))
                || ({1'b0, i_tube_index} >= f_eff(i_tube_segments));
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("fifo count out of range");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !pop |=> r_cnt == 2'd2)
        else $error("full fifo changed without pop");

endmodule
`default_nettype wire

// ----- rtl/core/tqt_trig.sv -----
// tqt_trig: back-end angle unit; bit-serial phase division then CORDIC, four lanes.
// Depends on tqt_pkg.
`default_nettype none
module tqt_trig
    import tqt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_item_valid,
    input  wire t_item               i_item,
    output logic                     o_pop,
    input  wire logic [CNT_W-1:0]    i_ring_segments,
    input  wire logic [CNT_W-1:0]    i_tube_segments,
    output logic                     o_valid,
    output t_trig                    o_trig,
    input  wire logic                i_take
);

    t_trig_state r_state, n_state;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_done, n_done;
    logic               r_bad;
    logic [CNT_W-1:0]   r_k   [4];
    logic [CNT_W-1:0]   r_n   [4];
    logic [CNT_W-1:0]   r_rem [4];
    logic [PH_W-1:0]    r_ph  [4];
    logic signed [33:0] r_x   [4];
    logic signed [33:0] r_y   [4];
    logic signed [32:0] r_z   [4];
    logic [1:0]         r_qd  [4];
    t_cs                cs    [4];
    logic               load, div_step, rot_step;
    logic [CNT_W-1:0]   m_eff, t_eff;

    assign m_eff = f_eff(i_ring_segments);
    assign t_eff = f_eff(i_tube_segments);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_done   = r_done;
        load     = 1'b0;
        div_step = 1'b0;
        rot_step = 1'b0;
        o_pop    = 1'b0;
        if (r_done && i_take) begin
            n_done = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && (!r_done || i_take)) begin
                    o_pop   = 1'b1;
                    load    = 1'b1;
                    n_cnt   = 6'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                div_step = 1'b1;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_cnt   = 6'd0;
                n_state = S_ROT;
            end
            S_ROT: begin
                rot_step = 1'b1;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 6'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [CNT_W-1:0]   trial;
        logic               ge;
        logic signed [33:0] dx, dy;
        logic signed [32:0] at;

        assign trial = {r_rem[l][CNT_W-2:0], r_k[l][CNT_W-1]};
        assign ge    = (trial >= r_n[l]);
        assign dx    = r_y[l] >>> r_cnt[3:0];
        assign dy    = r_x[l] >>> r_cnt[3:0];
        assign at    = f_atan(r_cnt[3:0]);
        assign cs[l] = f_quad(r_qd[l], f_cordic_out(r_x[l]), f_cordic_out(r_y[l]));

        always_ff @(posedge i_clk) begin
            if (load) begin
                r_rem[l] <= '0;
                r_ph[l]  <= '0;
                case (l)
                    0: begin r_k[l] <= {1'b0, i_item.ring_index};       r_n[l] <= m_eff; end
                    1: begin r_k[l] <= {1'b0, i_item.ring_index} + 1'b1; r_n[l] <= m_eff; end
                    2: begin r_k[l] <= {1'b0, i_item.tube_index};       r_n[l] <= t_eff; end
                    default: begin
                        r_k[l] <= {1'b0, i_item.tube_index} + 1'b1;
                        r_n[l] <= t_eff;
                    end
                endcase
            end else if (div_step) begin
                r_k[l]   <= {r_k[l][CNT_W-2:0], 1'b0};
                r_rem[l] <= ge ? trial - r_n[l] : trial;
                r_ph[l]  <= {r_ph[l][PH_W-2:0], ge};
            end
            if (r_state == S_LOAD) begin
                r_qd[l] <= r_ph[l][PH_W-1:PH_W-2];
                r_z[l]  <= 33'(r_ph[l][PH_W-3:0]);
                r_x[l]  <= 34'sd652032874;
                r_y[l]  <= '0;
            end else if (rot_step) begin
                if (!r_z[l][32]) begin
                    r_x[l] <= r_x[l] - dx;
                    r_y[l] <= r_y[l] + dy;
                    r_z[l] <= r_z[l] - at;
                end else begin
                    r_x[l] <= r_x[l] + dx;
                    r_y[l] <= r_y[l] - dy;
                    r_z[l] <= r_z[l] + at;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bad <= i_item.bad;
        end
    end

    assign o_valid    = r_done;
    assign o_trig.cu0 = cs[0].c;
    assign o_trig.su0 = cs[0].s;
    assign o_trig.cu1 = cs[1].c;
    assign o_trig.su1 = cs[1].s;
    assign o_trig.cv0 = cs[2].c;
    assign o_trig.sv0 = cs[2].s;
    assign o_trig.cv1 = cs[3].c;
    assign o_trig.sv1 = cs[3].s;
    assign o_trig.bad = r_bad;

    a_load_to_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_state == S_ROT)
        else $error("load not followed by rotation");

endmodule
`default_nettype wire

// ----- rtl/core/tqt_emit.sv -----
// tqt_emit: back-end corner sequencer; two-stage multiply pipeline into the output register.
// Depends on tqt_pkg.
`default_nettype none
module tqt_emit
    import tqt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_trig_valid,
    input  wire t_trig               i_trig,
    output logic                     o_take,
    input  wire logic [15:0]         i_ring_radius,
    input  wire logic [15:0]         i_tube_radius,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [2:0]               o_corner,
    output logic signed [18:0]       o_pos_x,
    output logic signed [18:0]       o_pos_y,
    output logic signed [18:0]       o_pos_z,
    output logic signed [15:0]       o_norm_x,
    output logic signed [15:0]       o_norm_y,
    output logic signed [15:0]       o_norm_z,
    output logic                     o_last_corner,
    output logic                     o_bad_index
);

    logic               en;
    logic               r_busy;
    logic [2:0]         r_n;
    t_trig              r_t;
    logic signed [15:0] cu, su, cv, sv;
    logic signed [32:0] p_rcv, p_rsv;
    logic signed [31:0] p_nx, p_nz;
    logic signed [39:0] ra_w;

    logic               r_a_valid;
    logic [2:0]         r_a_corner;
    logic signed [19:0] r_a_ra;
    logic signed [15:0] r_a_cu, r_a_su;
    logic signed [18:0] r_a_py;
    logic signed [15:0] r_a_nx, r_a_ny, r_a_nz;
    logic               r_a_bad;

    logic signed [35:0] p_px, p_pz;
    logic               r_o_valid;

    assign en     = !r_o_valid || !i_stall;
    assign o_take = i_trig_valid && (!r_busy || (en && r_n == 3'(LAST_CORNER)));

    always_comb begin
        cu = PICK_U[r_n] ? r_t.cu1 : r_t.cu0;
        su = PICK_U[r_n] ? r_t.su1 : r_t.su0;
        cv = PICK_V[r_n] ? r_t.cv1 : r_t.cv0;
        sv = PICK_V[r_n] ? r_t.sv1 : r_t.sv0;
        p_rcv = signed'({1'b0, i_tube_radius}) * cv;
        p_rsv = signed'({1'b0, i_tube_radius}) * sv;
        p_nx  = cv * cu;
        p_nz  = cv * su;
        ra_w  = 40'(signed'({1'b0, i_ring_radius})) + f_rnd14(40'(p_rcv));
        p_px  = r_a_ra * r_a_cu;
        p_pz  = r_a_ra * r_a_su;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_n       <= 3'd0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en) begin
                r_a_valid <= r_busy;
                r_o_valid <= r_a_valid;
                if (r_busy) begin
                    r_n <= (r_n == 3'(LAST_CORNER)) ? 3'd0 : r_n + 3'd1;
                    if (r_n == 3'(LAST_CORNER) && !o_take) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (o_take) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_t <= i_trig;
        end
        if (en) begin
            r_a_corner    <= r_n;
            r_a_ra        <= ra_w[19:0];
            r_a_cu        <= cu;
            r_a_su        <= su;
            r_a_py        <= f_sat_pos(f_rnd14(40'(p_rsv)));
            r_a_nx        <= f_sat_q14(f_rnd14(40'(p_nx)));
            r_a_ny        <= sv;
            r_a_nz        <= f_sat_q14(f_rnd14(40'(p_nz)));
            r_a_bad       <= r_t.bad;
            o_corner      <= r_a_corner;
            o_pos_x       <= f_sat_pos(f_rnd14(40'(p_px)));
            o_pos_y       <= r_a_py;
            o_pos_z       <= f_sat_pos(f_rnd14(40'(p_pz)));
            o_norm_x      <= r_a_nx;
            o_norm_y      <= r_a_ny;
            o_norm_z      <= r_a_nz;
            o_last_corner <= (r_a_corner == 3'(LAST_CORNER));
            o_bad_index   <= r_a_bad;
        end
    end

    assign o_valid = r_o_valid;

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_corner == (o_corner == 3'(LAST_CORNER)))
        else $error("last flag disagrees with corner");
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_corner |=> o_valid)
        else $error("gap inside a quad");
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_corner |=> o_corner == $past(o_corner) + 3'd1)
        else $error("corner order broken");

endmodule
`default_nettype wire
